FILE: sv/fenwick_tree_sum_search_top_defines.svh
// Assertion macros shared by the Fenwick tree sum and search block.
`ifndef FENWICK_TREE_SUM_SEARCH_TOP_DEFINES_SVH
`define FENWICK_TREE_SUM_SEARCH_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fts_pkg.sv
// Shared constants, types and helpers for the Fenwick tree sum and search block.
`default_nettype none

package fts_pkg;

  localparam int SIZE   = 1024;
  localparam int ADDR_W = $clog2(SIZE);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_QUERY,
    ST_SRCH_TOT,
    ST_SRCH
  } state_t;

  // Isolate the lowest set bit.
  function automatic idx_t low_bit(idx_t v);
    return v & idx_t'(~v + idx_t'(1));
  endfunction

endpackage

`default_nettype wire

FILE: sv/fts_in_if.sv
// Request channel carrying one tree operation.
`default_nettype none

interface fts_in_if;
  import fts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] amount;

  modport source (output valid, kind, index, amount, input ready);
  modport sink   (input valid, kind, index, amount, output ready);
endinterface

`default_nettype wire

FILE: sv/fts_out_if.sv
// Result channel carrying one query or search answer.
`default_nettype none

interface fts_out_if;
  import fts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] prefix_sum;
  logic [IDX_W-1:0]         position;
  logic                     not_found;

  modport source (output valid, prefix_sum, position, not_found, input ready);
  modport sink   (input valid, prefix_sum, position, not_found, output ready);
endinterface

`default_nettype wire

FILE: sv/fts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module fts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/fenwick_tree_sum_search_top.sv
// Fenwick tree over 1024 positions: point add, prefix sum query and prefix search.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_chan  | in  | valid / ready | kind, index, amount
//   out_chan | out | valid / ready | prefix_sum, position, not_found
//
// One request at a time; each tree entry is read through the single RAM read port.
// Add: updates each entry on the walk up; an index out of range leaves the tree alone.
// Query: sums the entries on the walk down from the clamped index.
// Search: reads the total, then probes one entry per level; not found when the target
// exceeds the total. Kind three is accepted and dropped without a result.
// After reset a clearing pass writes zero to all 1024 entries; in_chan.ready is low meanwhile.
// A finished result waits in the output register; the block stalls only when a new
// result is due while the previous one has not been taken.
`default_nettype none
`include "fenwick_tree_sum_search_top_defines.svh"

module fenwick_tree_sum_search_top (
  input  logic       clk,
  input  logic       rst_n,
  fts_in_if.sink     in_chan,
  fts_out_if.source  out_chan
);
  import fts_pkg::*;

  state_t          state_r, state_nxt;
  addr_t           clr_r, clr_nxt;
  idx_t            pos_r, pos_nxt;
  data_t           sum_r, sum_nxt;
  data_t           amt_r, amt_nxt;
  addr_t           base_r, base_nxt;
  addr_t           step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  data_t           out_sum_r, out_sum_nxt;
  idx_t            out_pos_r, out_pos_nxt;
  logic            out_nf_r, out_nf_nxt;

  logic            ram_we, ram_re;
  addr_t           ram_waddr, ram_raddr;
  data_t           ram_wdata, ram_rdata;

  logic            in_acc, out_free;
  logic            add_ok;
  idx_t            q_start;
  idx_t            lb;
  logic [IDX_W:0]  add_next;
  logic            add_end;
  idx_t            q_next;
  data_t           q_sum;
  logic            tot_ok;
  addr_t           probe;
  data_t           cand;
  logic            take;
  addr_t           base_sel;
  data_t           sum_sel;
  addr_t           step_half;
  logic            q_done, nf_done, s_done, res_load;

  fts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SIZE)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign in_acc              = in_chan.valid && in_chan.ready;
  assign out_free            = !out_valid_r || out_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.prefix_sum = out_sum_r;
  assign out_chan.position   = out_pos_r;
  assign out_chan.not_found  = out_nf_r;

  assign add_ok   = (in_chan.index != '0) && (in_chan.index <= idx_t'(SIZE));
  assign q_start  = (in_chan.index > idx_t'(SIZE)) ? idx_t'(SIZE) : in_chan.index;

  // Walk up for an add, down for a query.
  assign lb       = low_bit(pos_r);
  assign add_next = {1'b0, pos_r} + {1'b0, lb};
  assign add_end  = (add_next > (IDX_W+1)'(SIZE));
  assign q_next   = pos_r - lb;
  assign q_sum    = sum_r + ram_rdata;

  // Binary descent: step into the probe when its prefix still falls short.
  // Base is a sum of larger powers of two and step a smaller one, so the probe never carries out.
  assign tot_ok    = ($signed(ram_rdata) >= $signed(amt_r));
  assign probe     = base_r + step_r;
  assign cand      = sum_r + ram_rdata;
  assign take      = !($signed(cand) >= $signed(amt_r));
  assign base_sel  = take ? probe : base_r;
  assign sum_sel   = take ? cand : sum_r;
  assign step_half = step_r >> 1;

  assign q_done   = (state_r == ST_QUERY) && ((pos_r == '0) || (q_next == '0));
  assign nf_done  = (state_r == ST_SRCH_TOT) && !tot_ok;
  assign s_done   = (state_r == ST_SRCH) && (step_r == addr_t'(1));
  assign res_load = (q_done || nf_done || s_done) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == addr_t'(SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.kind)
            KIND_ADD: begin
              if (add_ok) begin
                state_nxt = ST_ADD;
              end
            end
            KIND_QUERY:  state_nxt = ST_QUERY;
            KIND_SEARCH: state_nxt = ST_SRCH_TOT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (add_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (q_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SRCH_TOT: begin
        if (tot_ok) begin
          state_nxt = ST_SRCH;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if (s_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result register
  always_comb begin
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    amt_nxt       = amt_r;
    base_nxt      = base_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_sum_nxt   = out_sum_r;
    out_pos_nxt   = out_pos_r;
    out_nf_nxt    = out_nf_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = '0;
      out_pos_nxt   = '0;
      out_nf_nxt    = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + addr_t'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.kind)
            KIND_ADD: begin
              pos_nxt   = in_chan.index;
              amt_nxt   = in_chan.amount;
              ram_re    = add_ok;
              ram_raddr = addr_t'(in_chan.index - idx_t'(1));
            end
            KIND_QUERY: begin
              pos_nxt   = q_start;
              sum_nxt   = '0;
              ram_re    = (q_start != '0);
              ram_raddr = addr_t'(q_start - idx_t'(1));
            end
            KIND_SEARCH: begin
              amt_nxt   = in_chan.amount;
              ram_re    = 1'b1;
              ram_raddr = addr_t'(SIZE - 1);
            end
            default: begin
              amt_nxt = amt_r;
            end
          endcase
        end
      end
      ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = addr_t'(pos_r - idx_t'(1));
        ram_wdata = ram_rdata + amt_r;
        if (!add_end) begin
          pos_nxt   = add_next[IDX_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = addr_t'(add_next[IDX_W-1:0] - idx_t'(1));
        end
      end
      ST_QUERY: begin
        if (q_done) begin
          if (out_free) begin
            out_sum_nxt = (pos_r == '0) ? sum_r : q_sum;
          end
        end else begin
          sum_nxt   = q_sum;
          pos_nxt   = q_next;
          ram_re    = 1'b1;
          ram_raddr = addr_t'(q_next - idx_t'(1));
        end
      end
      ST_SRCH_TOT: begin
        if (tot_ok) begin
          base_nxt  = '0;
          sum_nxt   = '0;
          step_nxt  = addr_t'(SIZE / 2);
          ram_re    = 1'b1;
          ram_raddr = addr_t'(SIZE / 2 - 1);
        end else if (out_free) begin
          out_nf_nxt = 1'b1;
        end
      end
      ST_SRCH: begin
        if (s_done) begin
          if (out_free) begin
            out_pos_nxt = idx_t'(base_sel) + idx_t'(1);
          end
        end else begin
          base_nxt  = base_sel;
          sum_nxt   = sum_sel;
          step_nxt  = step_half;
          ram_re    = 1'b1;
          ram_raddr = base_sel + step_half - addr_t'(1);
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    sum_r     <= sum_nxt;
    amt_r     <= amt_nxt;
    base_r    <= base_nxt;
    step_r    <= step_nxt;
    out_sum_r <= out_sum_nxt;
    out_pos_r <= out_pos_nxt;
    out_nf_r  <= out_nf_nxt;
  end

  `FTS_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
                  "read and write hit one entry")
  `FTS_ASSERT_NOW(a_load_free, res_load, !out_valid_r || out_chan.ready,
                  "result overwrites a pending one")
  `FTS_ASSERT_NOW(a_step_onehot, state_r == ST_SRCH, $onehot(step_r),
                  "search step not a power of two")
  `FTS_ASSERT_NEXT(a_add_zero_idle,
                   in_acc && (in_chan.kind == KIND_ADD) && (in_chan.index == '0),
                   state_r == ST_IDLE, "add at index zero started a walk")

endmodule

`default_nettype wire

FILE: bench/fenwick_tree_sum_search_top_tb.sv
// Testbench for the Fenwick tree block: mirrored tree, random and directed requests.
`timescale 1ns / 100ps

module fenwick_tree_sum_search_top_tb;
  import fts_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 163;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 200;

  typedef struct {
    data_t prefix_sum;
    idx_t  position;
    logic  not_found;
  } answer_t;

  // Mirror of the tree with the answers still due from the block.
  class tree_mirror;
    data_t   node_sum [1:SIZE];
    answer_t due_answers [$];
    int      errors;

    function new();
      foreach (node_sum[i]) node_sum[i] = '0;
      errors = 0;
    endfunction

    function data_t prefix_of(idx_t last);
      data_t acc;
      int    i;
      acc = '0;
      i = (last > SIZE) ? SIZE : int'(last);
      while (i > 0) begin
        acc += node_sum[i];
        i -= i & -i;
      end
      return acc;
    endfunction

    function answer_t search_for(data_t target);
      answer_t a;
      int      base;
      int      step;
      data_t   acc;
      a.prefix_sum = '0;
      a.position   = '0;
      a.not_found  = 1'b0;
      if ($signed(node_sum[SIZE]) < $signed(target)) begin
        a.not_found = 1'b1;
        return a;
      end
      base = 0;
      acc  = '0;
      for (step = SIZE; step > 0; step >>= 1) begin
        // advance only while the running sum stays below the target
        if (base + step <= SIZE &&
            $signed(data_t'(acc + node_sum[base + step])) < $signed(target)) begin
          base += step;
          acc  += node_sum[base];
        end
      end
      a.position = idx_t'(base + 1);
      return a;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, idx_t index, data_t amount);
      answer_t a;
      case (kind)
        KIND_ADD: begin
          if (index != 0 && index <= SIZE)
            for (int i = int'(index); i <= SIZE; i += i & -i) node_sum[i] += amount;
        end
        KIND_QUERY: begin
          a.prefix_sum = prefix_of(index);
          a.position   = '0;
          a.not_found  = 1'b0;
          due_answers.insert(due_answers.size(), a);
        end
        KIND_SEARCH: begin
          a = search_for(amount);
          due_answers.insert(due_answers.size(), a);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(data_t prefix_sum, idx_t position, logic not_found);
      answer_t a;
      if (due_answers.size() == 0) begin
        $error("unexpected answer: prefix_sum %0d position %0d not_found %0b",
               $signed(prefix_sum), position, not_found);
        errors++;
        return;
      end
      a = due_answers.pop_front();
      if (prefix_sum !== a.prefix_sum) begin
        $error("prefix_sum: expected %0d, got %0d",
               $signed(a.prefix_sum), $signed(prefix_sum));
        errors++;
      end
      if (position !== a.position) begin
        $error("position: expected %0d, got %0d", a.position, position);
        errors++;
      end
      if (not_found !== a.not_found) begin
        $error("not_found: expected %0b, got %0b", a.not_found, not_found);
        errors++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int answers_seen  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  tree_mirror mirror = new();

  fts_in_if  in_chan ();
  fts_out_if out_chan ();

  fenwick_tree_sum_search_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        mirror.check_answer(out_chan.prefix_sum, out_chan.position, out_chan.not_found);
        answers_seen++;
      end
      if (in_chan.valid && in_chan.ready)
        mirror.note_request(in_chan.kind, in_chan.index, in_chan.amount);
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input idx_t index,
                              input data_t amount);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.kind   <= kind;
    in_chan.index  <= index;
    in_chan.amount <= amount;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding answer has come back.
  task automatic drain_answers();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (mirror.due_answers.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(output bit counted);
    logic [KIND_W-1:0] kind;
    idx_t              index;
    data_t             amount;
    data_t             total;
    int                pick;
    pick = $urandom_range(99);
    kind = (pick < 3)  ? KIND_SPARE :
           (pick < 43) ? KIND_ADD   :
           (pick < 68) ? KIND_QUERY : KIND_SEARCH;
    pick = $urandom_range(99);
    index = (pick < 90) ? idx_t'($urandom_range(SIZE, 1)) :
            (pick < 95) ? idx_t'(0) : idx_t'($urandom_range(2047, SIZE + 1));
    pick = $urandom_range(99);
    total = mirror.prefix_of(idx_t'(SIZE));
    if (kind == KIND_SEARCH) begin
      // keep most targets inside the current total so the descent is exercised
      if ($signed(total) > 0 && pick < 80)
        amount = data_t'($urandom_range(total, 1));
      else if ($signed(total) >= 0 && pick < 90)
        amount = total + data_t'($urandom_range(100, 1));
      else
        amount = data_t'($urandom);
    end else begin
      amount = (pick < 85) ? data_t'($urandom_range(1000)) :
               (pick < 97) ? -data_t'($urandom_range(50, 1)) : data_t'($urandom);
    end
    send_request(kind, index, amount);
    counted = (kind != KIND_SPARE);
  endtask

  initial begin
    bit counted;
    int sent;
    in_chan.valid  = 1'b0;
    in_chan.kind   = KIND_ADD;
    in_chan.index  = '0;
    in_chan.amount = '0;
    out_chan.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree: zero query, saturated query, trivial and failing searches
    send_request(KIND_QUERY,  idx_t'(0),    data_t'(0));
    send_request(KIND_QUERY,  idx_t'(2047), data_t'(0));
    send_request(KIND_SEARCH, idx_t'(0),    data_t'(0));
    send_request(KIND_SEARCH, idx_t'(5),    data_t'(1));
    send_request(KIND_SEARCH, idx_t'(5),    32'h8000_0000);
    // adds out of range leave the tree alone; then adds, queries, searches and a spare kind
    send_request(KIND_ADD,    idx_t'(0),    data_t'(5));
    send_request(KIND_ADD,    idx_t'(1025), data_t'(7));
    send_request(KIND_ADD,    idx_t'(2047), data_t'(9));
    send_request(KIND_ADD,    idx_t'(1),    data_t'(3));
    send_request(KIND_ADD,    idx_t'(1024), data_t'(10));
    send_request(KIND_ADD,    idx_t'(512),  data_t'(4));
    send_request(KIND_ADD,    idx_t'(1023), data_t'(1));
    send_request(KIND_QUERY,  idx_t'(511),  data_t'(0));
    send_request(KIND_QUERY,  idx_t'(1023), data_t'(0));
    send_request(KIND_QUERY,  idx_t'(1500), data_t'(0));
    send_request(KIND_SEARCH, idx_t'(0),    data_t'(4));
    send_request(KIND_SEARCH, idx_t'(0),    data_t'(8));
    send_request(KIND_SEARCH, idx_t'(0),    data_t'(18));
    send_request(KIND_SEARCH, idx_t'(0),    -data_t'(1));
    send_request(KIND_SPARE,  idx_t'(2047), 32'hFFFF_FFFF);
    // push the total through the signed extremes and back
    send_request(KIND_ADD,    idx_t'(700),  32'h7FFF_FFFF);
    send_request(KIND_QUERY,  idx_t'(1024), data_t'(0));
    send_request(KIND_SEARCH, idx_t'(0),    32'h7FFF_FFFF);
    send_request(KIND_ADD,    idx_t'(700),  32'h8000_0001);
    send_request(KIND_QUERY,  idx_t'(700),  data_t'(0));
    drain_answers();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) sent++;
      end
      drain_answers();
    end

    repeat (30) @(posedge clk);
    if (mirror.errors == 0 && mirror.due_answers.size() == 0) begin
      $display("fenwick_tree_sum_search_top: match");
    end else begin
      $display("fenwick_tree_sum_search_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("fenwick_tree_sum_search_top: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/fts_pkg.sv
sv/fts_in_if.sv
sv/fts_out_if.sv
sv/fts_ram.sv
sv/fenwick_tree_sum_search_top.sv
bench/fenwick_tree_sum_search_top_tb.sv
